// ----- hw/rtl/rac_pkg.sv -----
// Package for the radix ASCII converter: beat types, cell link type,
// register indexes and the digit-to-ASCII mapping. No dependencies.
package rac_pkg;

  localparam int unsigned NumberW   = 64;
  localparam int unsigned NibW      = 4;
  localparam int unsigned NumCells  = NumberW / NibW;
  localparam int unsigned DigitW    = 6;
  localparam int unsigned CharW     = 7;
  localparam int unsigned MaxDigits = 64;
  localparam int unsigned CntW      = $clog2(MaxDigits + 1);
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 6;

  localparam logic [CfgIdxW-1:0] RegRadix = 1'b0;
  localparam logic [CfgIdxW-1:0] RegUpper = 1'b1;

  localparam logic [DigitW-1:0] RadixMin   = 6'd2;
  localparam logic [DigitW-1:0] RadixMax   = 6'd36;
  localparam logic [DigitW-1:0] RadixReset = 6'd10;
  localparam logic [DigitW-1:0] DecLimit   = 6'd10;

  localparam logic [CharW-1:0] AsciiZero  = 7'd48;
  localparam logic [CharW-1:0] AsciiUpper = 7'd65;
  localparam logic [CharW-1:0] AsciiLower = 7'd97;

  typedef struct packed {
    logic [NumberW-1:0] number_in;
  } in_beat_t;

  typedef struct packed {
    logic [CharW-1:0] char_out;
    logic             last_char;
  } out_beat_t;

  // One division wave passing from a more significant cell to the next.
  typedef struct packed {
    logic              valid;
    logic              nz;
    logic [DigitW-1:0] rem;
  } div_link_t;

  function automatic logic [CharW-1:0] digit_ascii(logic [DigitW-1:0] d, logic upper);
    logic [CharW-1:0] base;
    if (d < DecLimit) begin
      digit_ascii = AsciiZero + {1'b0, d};
    end else begin
      base = upper ? AsciiUpper : AsciiLower;
      digit_ascii = base + {1'b0, d} - {1'b0, DecLimit};
    end
  endfunction

endpackage

// ----- hw/rtl/rac_stream_if.sv -----
// Valid/ready stream interface used for the input and output channels.
// Depends on nothing; the payload type is a parameter.
interface rac_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/radix_ascii_converter_unit.sv -----
// Radix ASCII converter top level: a 16-cell systolic divider chain feeds a
// 64-cell digit stack that is emitted most significant digit first.
// A new value is accepted only in the idle state once the chain holds no
// division wave; each wave ripples through the 16 cells, and the stack pops one
// digit per character taken by the output.
// Reset: asynchronous, active low; radix returns to 10, letters to lowercase.
module radix_ascii_converter_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rac_pkg::CfgDataW-1:0] cfg_data_i,
  rac_stream_if.sink                   in_i,
  rac_stream_if.source                 out_o
);
  import rac_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [DigitW-1:0] radix_q;
  logic              upper_q;

  div_link_t         links [NumCells];
  div_link_t         head_link;
  logic [NumCells-1:0] busy_vec;
  logic              chain_busy;
  logic              in_fire, out_fire, push, pop;
  logic [DigitW-1:0] stack [MaxDigits];
  in_beat_t          in_beat;
  out_beat_t         out_beat;

  // Configuration registers, radix clamped to its legal range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
      upper_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRadix: begin
          if (cfg_data_i < RadixMin) begin
            radix_q <= RadixMin;
          end else if (cfg_data_i > RadixMax) begin
            radix_q <= RadixMax;
          end else begin
            radix_q <= cfg_data_i;
          end
        end
        RegUpper: upper_q <= cfg_data_i[0];
        default:  ;
      endcase
    end
  end

  assign in_beat   = in_i.payload;
  assign in_i.ready = (state_q == StIdle) && !chain_busy;
  assign in_fire   = in_i.valid && in_i.ready;

  // Issue one division wave per cycle while converting.
  assign head_link = '{valid: (state_q == StConv), nz: 1'b0, rem: '0};

  for (genvar i = 0; i < NumCells; i++) begin : g_div
    rac_div_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (in_fire),
      .load_nib_i (in_beat.number_in[i*NibW +: NibW]),
      .radix_i    (radix_q),
      .link_i     ((i == NumCells - 1) ? head_link : links[(i + 1) % NumCells]),
      .link_o     (links[i])
    );
    assign busy_vec[i] = links[i].valid;
  end

  assign chain_busy = |busy_vec;

  // Waves still in flight after the final digit are dropped.
  assign push     = (state_q == StConv) && links[0].valid;
  assign out_fire = out_o.valid && out_o.ready;
  assign pop      = out_fire;

  for (genvar k = 0; k < MaxDigits; k++) begin : g_stack
    rac_stack_cell u_slot (
      .clk_i   (clk_i),
      .push_i  (push),
      .pop_i   (pop),
      .upper_i ((k == 0) ? links[0].rem : stack[(k + MaxDigits - 1) % MaxDigits]),
      .lower_i ((k == MaxDigits - 1) ? '0 : stack[(k + 1) % MaxDigits]),
      .digit_o (stack[k])
    );
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StConv;
          count_d = '0;
        end
      end
      StConv: begin
        if (push) begin
          count_d = count_q + CntW'(1);
          if (!links[0].nz) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        if (pop) begin
          count_d = count_q - CntW'(1);
          if (count_q == CntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  assign out_beat.char_out  = digit_ascii(stack[0], upper_q);
  assign out_beat.last_char = (count_q == CntW'(1));
  assign out_o.valid        = (state_q == StEmit);
  assign out_o.payload      = out_beat;

endmodule

// ----- hw/rtl/rac_div_cell.sv -----
// One nibble cell of the systolic divider: holds four bits of the value,
// divides them by the radix with the remainder from its upper neighbour.
// Depends on rac_pkg.
module rac_div_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [rac_pkg::NibW-1:0]    load_nib_i,
  input  logic [rac_pkg::DigitW-1:0]  radix_i,
  input  rac_pkg::div_link_t          link_i,
  output rac_pkg::div_link_t          link_o
);
  import rac_pkg::*;

  logic [NibW-1:0]   nib_q, nib_d;
  logic [DigitW-1:0] rem_q, rem_d;
  logic              valid_q, nz_q;
  logic [NibW-1:0]   quot;

  // Restoring division of {rem_in, nib} by the radix, one bit a step.
  always_comb begin
    logic [DigitW:0] part;
    part = {1'b0, link_i.rem};
    quot = '0;
    for (int b = NibW - 1; b >= 0; b--) begin
      part = {part[DigitW-1:0], nib_q[b]};
      if (part >= {1'b0, radix_i}) begin
        part    = part - {1'b0, radix_i};
        quot[b] = 1'b1;
      end
    end
    rem_d = part[DigitW-1:0];
  end

  always_comb begin
    nib_d = nib_q;
    if (load_i) begin
      nib_d = load_nib_i;
    end else if (link_i.valid) begin
      nib_d = quot;
    end
  end

  always_ff @(posedge clk_i) begin
    nib_q <= nib_d;
    rem_q <= rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      nz_q    <= 1'b0;
    end else begin
      valid_q <= link_i.valid;
      nz_q    <= link_i.nz | (quot != '0);
    end
  end

  assign link_o = '{valid: valid_q, nz: nz_q, rem: rem_q};

endmodule

// ----- hw/rtl/rac_stack_cell.sv -----
// One cell of the digit stack: shifts deeper on push, towards the head on pop.
// Depends on rac_pkg.
module rac_stack_cell (
  input  logic                       clk_i,
  input  logic                       push_i,
  input  logic                       pop_i,
  input  logic [rac_pkg::DigitW-1:0] upper_i,
  input  logic [rac_pkg::DigitW-1:0] lower_i,
  output logic [rac_pkg::DigitW-1:0] digit_o
);
  import rac_pkg::*;

  logic [DigitW-1:0] digit_q, digit_d;

  always_comb begin
    digit_d = digit_q;
    if (push_i) begin
      digit_d = upper_i;
    end else if (pop_i) begin
      digit_d = lower_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule
